[hw/rtl/dwq_pkg.sv]
`timescale 1ns / 1ps

package dwq_pkg;

	// Default sizes of the queue and of the delayed slot table.
	localparam int QUEUE_DEPTH_DEF = 64;
	localparam int DELAY_SLOTS_DEF = 16;

	// Fixed widths of the stream fields.
	localparam int HANDLER_W = 32;
	localparam int CONTEXT_W = 64;
	localparam int DELAY_W   = 32;
	localparam int TIME_W    = 64;
	localparam int SLOT_W    = 4;
	localparam int FIRED_W   = 5;
	localparam int QCOUNT_W  = 7;
	localparam int IN_DATA_W  = 128;
	localparam int OUT_DATA_W = 120;

	// Operation carried in the input tuser.
	typedef enum logic [1:0] {
		OP_SUBMIT = 2'd0,
		OP_DELAY  = 2'd1,
		OP_TICK   = 2'd2,
		OP_DRAIN  = 2'd3
	} op_t;

	// Result kind carried in the output tuser.
	typedef enum logic [2:0] {
		KIND_SUBMIT = 3'd0,
		KIND_DELAY  = 3'd1,
		KIND_TICK   = 3'd2,
		KIND_WORK   = 3'd3,
		KIND_EMPTY  = 3'd4
	} kind_t;

	// Which result the datapath loads into its output register.
	typedef enum logic [2:0] {
		EM_NONE,
		EM_SUBMIT,
		EM_DELAY,
		EM_TICK,
		EM_PEND_MID,
		EM_PEND_LAST,
		EM_EMPTY
	} emit_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_T_INC,
		ST_T_SCAN,
		ST_T_EMIT,
		ST_D_RD,
		ST_D_DATA,
		ST_D_END
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic  latch_in;
		logic  scan_clr;
		logic  time_inc;
		logic  scan_step;
		logic  rd_issue;
		logic  pend_load;
		emit_t emit;
	} dwq_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;
		logic cnt_zero;
		logic scan_last;
		logic rd_nonzero;
		logic pend_valid;
	} dwq_stat_t;

endpackage

[hw/rtl/dwq_ctrl.sv]
`timescale 1ns / 1ps

module dwq_ctrl import dwq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  op_t       in_op,
	input  dwq_stat_t stat,
	output logic      in_ready,
	output dwq_cmd_t  cmd
);

	state_t state_q, state_d;
	op_t    op_q;

	// State register and the latched operation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_SUBMIT;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && in_valid) begin
				op_q <= in_op;
			end
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '{latch_in: 1'b0, scan_clr: 1'b0, time_inc: 1'b0, scan_step: 1'b0,
			rd_issue: 1'b0, pend_load: 1'b0, emit: EM_NONE};
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					unique case (in_op)
						OP_SUBMIT, OP_DELAY: state_d = ST_EXEC;
						OP_TICK: begin
							cmd.scan_clr = 1'b1;
							state_d      = ST_T_INC;
						end
						OP_DRAIN: state_d = ST_D_RD;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_EXEC: begin
				if (stat.out_free) begin
					cmd.emit = (op_q == OP_SUBMIT) ? EM_SUBMIT : EM_DELAY;
					state_d  = ST_IDLE;
				end
			end
			ST_T_INC: begin
				cmd.time_inc = 1'b1;
				state_d      = ST_T_SCAN;
			end
			ST_T_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_last) begin
					state_d = ST_T_EMIT;
				end
			end
			ST_T_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = EM_TICK;
					state_d  = ST_IDLE;
				end
			end
			ST_D_RD: begin
				if (stat.cnt_zero) begin
					state_d = ST_D_END;
				end else begin
					cmd.rd_issue = 1'b1;
					state_d      = ST_D_DATA;
				end
			end
			ST_D_DATA: begin
				// A nonzero handler becomes the pending word; the older one goes out.
				if (!stat.rd_nonzero) begin
					state_d = ST_D_RD;
				end else if (!stat.pend_valid) begin
					cmd.pend_load = 1'b1;
					state_d       = ST_D_RD;
				end else if (stat.out_free) begin
					cmd.emit      = EM_PEND_MID;
					cmd.pend_load = 1'b1;
					state_d       = ST_D_RD;
				end
			end
			ST_D_END: begin
				if (stat.out_free) begin
					cmd.emit = stat.pend_valid ? EM_PEND_LAST : EM_EMPTY;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

[hw/rtl/dwq_dp.sv]
`timescale 1ns / 1ps

module dwq_dp import dwq_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int DELAY_SLOTS = DELAY_SLOTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dwq_cmd_t              cmd,
	input  logic [IN_DATA_W-1:0]  in_data,
	input  logic                  out_ready,
	output dwq_stat_t             stat,
	output logic                  out_valid,
	output logic [2:0]            out_kind,
	output logic [OUT_DATA_W-1:0] out_data,
	output logic                  out_last
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = (DELAY_SLOTS > 1) ? $clog2(DELAY_SLOTS) : 1;
	localparam int FW = $clog2(DELAY_SLOTS + 1);

	// Latched input word.
	logic [HANDLER_W-1:0] handler_q;
	logic [CONTEXT_W-1:0] ctx_q;
	logic [DELAY_W-1:0]   delay_q;

	// Queue memory and pointers.
	logic [HANDLER_W-1:0] mem_h [QUEUE_DEPTH];
	logic [CONTEXT_W-1:0] mem_c [QUEUE_DEPTH];
	logic [HANDLER_W-1:0] rd_h_q;
	logic [CONTEXT_W-1:0] rd_c_q;
	logic [PW-1:0]        head_q, tail_q;
	logic [CW-1:0]        count_q;

	// Delayed slots.
	logic [DELAY_SLOTS-1:0] active_q;
	logic [HANDLER_W-1:0]   slot_h_q [DELAY_SLOTS];
	logic [CONTEXT_W-1:0]   slot_c_q [DELAY_SLOTS];
	logic [TIME_W-1:0]      slot_t_q [DELAY_SLOTS];
	logic [TIME_W-1:0]      time_q;

	// Tick scan and drain state.
	logic [SW-1:0]        scan_q;
	logic [FW-1:0]        fired_q, dropped_q;
	logic [HANDLER_W-1:0] pend_h_q;
	logic [CONTEXT_W-1:0] pend_c_q;
	logic                 pend_valid_q;

	// Output register.
	logic                  out_valid_q;
	logic [2:0]            out_kind_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic                  out_last_q;

	logic          full, out_free, hit, any_free, wr_en;
	logic [SW-1:0] free_idx;
	logic [PW-1:0] wr_addr;
	logic [HANDLER_W-1:0] wr_h;
	logic [CONTEXT_W-1:0] wr_c;

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		ptr_next = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full     = (count_q == CW'(QUEUE_DEPTH));
	assign out_free = !out_valid_q || out_ready;
	assign hit      = active_q[scan_q] && (time_q >= slot_t_q[scan_q]);

	// First free delayed slot.
	always_comb begin
		any_free = 1'b0;
		free_idx = '0;
		for (int i = DELAY_SLOTS - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				any_free = 1'b1;
				free_idx = SW'(i);
			end
		end
	end

	// One queue write port, shared by submit and tick.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = tail_q;
		wr_h    = handler_q;
		wr_c    = ctx_q;
		if (cmd.emit == EM_SUBMIT && !full) begin
			wr_en = 1'b1;
		end else if (cmd.scan_step && hit && !full) begin
			wr_en = 1'b1;
			wr_h  = slot_h_q[scan_q];
			wr_c  = slot_c_q[scan_q];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_h[wr_addr] <= wr_h;
			mem_c[wr_addr] <= wr_c;
		end
		if (cmd.rd_issue) begin
			rd_h_q <= mem_h[head_q];
			rd_c_q <= mem_c[head_q];
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			handler_q <= in_data[HANDLER_W-1:0];
			ctx_q     <= in_data[HANDLER_W+CONTEXT_W-1:HANDLER_W];
			delay_q   <= in_data[IN_DATA_W-1:HANDLER_W+CONTEXT_W];
		end
		if (cmd.emit == EM_DELAY && any_free) begin
			slot_h_q[free_idx] <= handler_q;
			slot_c_q[free_idx] <= ctx_q;
			slot_t_q[free_idx] <= time_q + TIME_W'(delay_q);
		end
		if (cmd.pend_load) begin
			pend_h_q <= rd_h_q;
			pend_c_q <= rd_c_q;
		end
	end

	// Pointers, counters, slot valid bits and time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			tail_q       <= '0;
			count_q      <= '0;
			active_q     <= '0;
			time_q       <= '0;
			scan_q       <= '0;
			fired_q      <= '0;
			dropped_q    <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				tail_q  <= ptr_next(tail_q);
				count_q <= count_q + 1'b1;
			end
			if (cmd.rd_issue) begin
				head_q  <= ptr_next(head_q);
				count_q <= count_q - 1'b1;
			end
			if (cmd.time_inc) begin
				time_q <= time_q + 1'b1;
			end
			if (cmd.emit == EM_DELAY && any_free) begin
				active_q[free_idx] <= 1'b1;
			end
			if (cmd.scan_clr) begin
				scan_q    <= '0;
				fired_q   <= '0;
				dropped_q <= '0;
			end else if (cmd.scan_step) begin
				scan_q <= scan_q + 1'b1;
				if (hit) begin
					active_q[scan_q] <= 1'b0;
					if (full) begin
						dropped_q <= dropped_q + 1'b1;
					end else begin
						fired_q <= fired_q + 1'b1;
					end
				end
			end
			if (cmd.pend_load) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.emit == EM_PEND_LAST) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	// Output word register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit != EM_NONE) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		logic                 st;
		logic [SLOT_W-1:0]    sl;
		logic [HANDLER_W-1:0] wh;
		logic [CONTEXT_W-1:0] wc;
		logic [FIRED_W-1:0]   fi, dr;
		logic [QCOUNT_W-1:0]  qc;
		st = 1'b0;
		sl = '0;
		wh = '0;
		wc = '0;
		fi = '0;
		dr = '0;
		qc = '0;
		if (cmd.emit != EM_NONE) begin
			out_last_q <= 1'b1;
			unique case (cmd.emit)
				EM_SUBMIT: begin
					out_kind_q <= KIND_SUBMIT;
					st = full;
					qc = full ? QCOUNT_W'(count_q) : QCOUNT_W'(count_q + 1'b1);
				end
				EM_DELAY: begin
					out_kind_q <= KIND_DELAY;
					st = !any_free;
					sl = any_free ? SLOT_W'(free_idx) : '0;
					qc = QCOUNT_W'(count_q);
				end
				EM_TICK: begin
					out_kind_q <= KIND_TICK;
					fi = FIRED_W'(fired_q);
					dr = FIRED_W'(dropped_q);
					qc = QCOUNT_W'(count_q);
				end
				EM_PEND_MID, EM_PEND_LAST: begin
					out_kind_q <= KIND_WORK;
					out_last_q <= (cmd.emit == EM_PEND_LAST);
					wh = pend_h_q;
					wc = pend_c_q;
				end
				EM_EMPTY: out_kind_q <= KIND_EMPTY;
				default: out_kind_q <= KIND_EMPTY;
			endcase
			out_data_q <= {2'b00, qc, dr, fi, wc, wh, sl, st};
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_data  = out_data_q;
	assign out_last  = out_last_q;

	assign stat.out_free   = out_free;
	assign stat.cnt_zero   = (count_q == '0);
	assign stat.scan_last  = (scan_q == SW'(DELAY_SLOTS - 1));
	assign stat.rd_nonzero = (rd_h_q != '0);
	assign stat.pend_valid = pend_valid_q;

	// The queue never holds more than its depth.
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CW'(QUEUE_DEPTH))
		else $error("queue count above depth");

	// An empty or full queue has its pointers together.
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0 || full) |-> (head_q == tail_q))
		else $error("queue pointers disagree with count");

	// A result is never loaded over one that has not been taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit != EM_NONE) |-> out_free)
		else $error("output word overwritten");

	// Reads and writes of the queue never meet in one cycle.
	assert property (@(posedge clk) disable iff (!arst_n) !(cmd.rd_issue && wr_en))
		else $error("queue read and write together");

endmodule

[hw/rtl/deferred_work_queue_unit.sv]
`timescale 1ns / 1ps
// Channel  | Signals                         | Word
// s_axis   | tvalid tready tdata tuser       | request: tuser op, tdata handler/context/delay
// m_axis   | tvalid tready tdata tuser tlast | result: tuser kind, tlast last
//
// Submit and delay pass through the execute step to their result. Tick
// increments time, then scans the delayed slots in turn through one compare.
// Drain reads the queued entries in turn through the registered queue read.
// Reset clears pointers, counts, time and slot valid bits; no clearing pass.
// A stalled output holds the block in the step that wants to send a word.

module deferred_work_queue_unit import dwq_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int DELAY_SLOTS = DELAY_SLOTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// handler [31:0], context_req [95:32], delay [127:96]
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// op [1:0]
	input  logic [1:0]            s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// status [0], slot [4:1], work_handler [36:5], work_context [100:37],
	// fired [105:101], dropped [110:106], queue_count [117:111]
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// kind [2:0]
	output logic [2:0]            m_axis_tuser,
	output logic                  m_axis_tlast
);

	dwq_cmd_t  cmd;
	dwq_stat_t stat;

	dwq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_op    (op_t'(s_axis_tuser)),
		.stat     (stat),
		.in_ready (s_axis_tready),
		.cmd      (cmd)
	);

	dwq_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.DELAY_SLOTS (DELAY_SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (s_axis_tdata),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.out_valid (m_axis_tvalid),
		.out_kind  (m_axis_tuser),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule
